// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL; clocked on clk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SWC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication
`define SWC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/swc_pkg.sv -----
`timescale 1ns / 1ps
package swc_pkg;

	localparam int IDX_W = 12;
	localparam int LEN_W = 13;
	localparam int PER_W = 20;
	localparam int VAL_W = 18;
	localparam int DIV_W = 47;
	localparam int QF_W  = 18;
	localparam int QQ_W  = 31;

	// 2*pi in Q32
	localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
	localparam logic [QQ_W-1:0] SIN_C11 = 31'd3864;
	// Horner coefficients, innermost first: c9, c7, c5, c3, c1
	localparam logic [QQ_W-1:0] HORNER_C [5] = '{
		31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
	};
	localparam logic [VAL_W-1:0] VAL_ONE = 18'd65536;

	typedef enum logic {
		REG_LENGTH = 1'b0,
		REG_PERIOD = 1'b1
	} swc_reg_t;

	typedef struct packed {
		logic oor;
		logic dz;
		logic neg;
	} swc_flag_t;

endpackage

// ----- rtl/swc_div_pipe.sv -----
`timescale 1ns / 1ps
module swc_div_pipe #(
	parameter int N  = 47,
	parameter int M  = 20,
	parameter int L  = 2,
	parameter int SW = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [L-1:0][N-1:0]    in_num,
	input  logic [L-1:0][M-1:0]    in_rem,
	input  logic [M-1:0]           in_den,
	input  logic [SW-1:0]          in_side,
	output logic                   out_vld,
	output logic [L-1:0][N-1:0]    out_quo,
	output logic [SW-1:0]          out_side
);

	logic [N-1:0]          vld_q;
	logic [L-1:0][N-1:0]   num_q  [N];
	logic [L-1:0][M-1:0]   rem_q  [N];
	logic [M-1:0]          den_q  [N];
	logic [SW-1:0]         side_q [N];

	// One restoring step per stage; all lanes share the divisor
	for (genvar k = 0; k < N; k++) begin : g_stg
		logic                 p_vld;
		logic [L-1:0][N-1:0]  p_num;
		logic [L-1:0][M-1:0]  p_rem;
		logic [M-1:0]         p_den;
		logic [SW-1:0]        p_side;
		logic [L-1:0][N-1:0]  nx_num;
		logic [L-1:0][M-1:0]  nx_rem;
		logic [M:0]           trial;
		logic                 ge;

		if (k == 0) begin : g_first
			assign p_vld  = in_vld;
			assign p_num  = in_num;
			assign p_rem  = in_rem;
			assign p_den  = in_den;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_q[k-1];
			assign p_num  = num_q[k-1];
			assign p_rem  = rem_q[k-1];
			assign p_den  = den_q[k-1];
			assign p_side = side_q[k-1];
		end

		// shift in the next numerator bit, subtract when it fits
		always_comb begin
			trial  = '0;
			ge     = 1'b0;
			nx_num = '0;
			nx_rem = '0;
			for (int j = 0; j < L; j++) begin
				trial     = {p_rem[j], p_num[j][N-1]};
				ge        = trial >= {1'b0, p_den};
				nx_num[j] = {p_num[j][N-2:0], ge};
				nx_rem[j] = ge ? M'(trial - {1'b0, p_den}) : trial[M-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k]  <= nx_num;
				rem_q[k]  <= nx_rem;
				den_q[k]  <= p_den;
				side_q[k] <= p_side;
			end
		end
	end

	assign out_vld  = vld_q[N-1];
	assign out_quo  = num_q[N-1];
	assign out_side = side_q[N-1];

endmodule

// ----- rtl/sinc_window_coefficient.sv -----
`timescale 1ns / 1ps
// Sinc window coefficient generator: one coefficient (signed Q1.16) per index, fully
// pipelined, accepting one index every clock cycle while the output is taken. Pipeline
// depth is set by two long-division pipelines (one quotient bit per stage: 47 stages
// for angle in turns and radians, 18 for the final sin(x)/x quotient) plus the seven
// multiplier stages of the sine polynomial. A stall on the output freezes the whole
// pipeline; no item is lost or repeated. Register 0 sets window length, register 1
// the period in Q12.8; write them only while idle.
module sinc_window_coefficient #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [11:0] coeff_index
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [17:0] coeff_value
	output logic                 m_tuser,   // [0] out_of_range
	input  logic                 cfg_we,
	input  swc_pkg::swc_reg_t    cfg_index,
	input  logic [19:0]          cfg_data
);
	import swc_pkg::*;

	logic             en;
	logic [LEN_W-1:0] len_q;
	logic [PER_W-1:0] per_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
			per_q <= PER_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LENGTH: len_q <= cfg_data[LEN_W-1:0];
				REG_PERIOD: per_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// advance the pipeline unless the output holds an untaken item
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: range check, distance from center
	logic [IDX_W-1:0] idx_c, ctr_c, d_c;
	logic [LEN_W-1:0] leff_c;
	logic [PER_W-1:0] per_c;
	logic             vld_s1;
	swc_flag_t        flg_s1;
	logic [IDX_W-1:0] d_s1;
	logic [PER_W-1:0] per_s1;

	always_comb begin
		idx_c  = s_tdata[IDX_W-1:0];
		leff_c = ({19'b0, len_q} > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_q;
		ctr_c  = leff_c[LEN_W-1:1];
		d_c    = (idx_c >= ctr_c) ? (idx_c - ctr_c) : (ctr_c - idx_c);
		per_c  = (per_q == '0) ? PER_W'(1) : per_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s1.oor <= {1'b0, idx_c} >= leff_c;
			flg_s1.dz  <= d_c == '0;
			flg_s1.neg <= 1'b0;
			d_s1       <= d_c;
			per_s1     <= per_c;
		end
	end

	// stage 2: angle numerator in radians
	logic             vld_s2;
	swc_flag_t        flg_s2;
	logic [IDX_W-1:0] d_s2;
	logic [DIV_W-1:0] numx_s2;
	logic [PER_W-1:0] per_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s2  <= flg_s1;
			d_s2    <= d_s1;
			numx_s2 <= DIV_W'(d_s1) * DIV_W'(TWO_PI_Q32);
			per_s2  <= per_s1;
		end
	end

	// divide d*2^32 (turns) and d*2*pi*2^32 (radians) by the period
	logic [1:0][DIV_W-1:0] ang_num;
	logic                  ang_vld;
	logic [1:0][DIV_W-1:0] ang_quo;
	swc_flag_t             ang_flg;

	assign ang_num[0] = {3'b0, d_s2, 32'b0};
	assign ang_num[1] = numx_s2;

	swc_div_pipe #(.N(DIV_W), .M(PER_W), .L(2), .SW($bits(swc_flag_t))) u_ang_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_num   (ang_num),
		.in_rem   ('0),
		.in_den   (per_s2),
		.in_side  (flg_s2),
		.out_vld  (ang_vld),
		.out_quo  (ang_quo),
		.out_side (ang_flg)
	);

	// stage 3: quadrant fold of the turn fraction
	logic [1:0]       quad_c;
	logic [22:0]      u_c;
	logic             vld_s3;
	swc_flag_t        flg_s3;
	logic [QQ_W-1:0]  uq_s3;
	logic [DIV_W-1:0] x_s3;

	always_comb begin
		quad_c = ang_quo[0][23:22];
		u_c    = quad_c[0] ? (23'h400000 - {1'b0, ang_quo[0][21:0]})
		                   : {1'b0, ang_quo[0][21:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= ang_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s3.oor <= ang_flg.oor;
			flg_s3.dz  <= ang_flg.dz;
			flg_s3.neg <= quad_c[1];
			uq_s3      <= {u_c, 8'b0};
			x_s3       <= ang_quo[1];
		end
	end

	// stage 4: u squared
	logic [2*QQ_W-1:0] sq_c;
	logic              vld_s4;
	swc_flag_t         flg_s4;
	logic [QQ_W-1:0]   uq_s4, u2_s4;
	logic [DIV_W-1:0]  x_s4;

	assign sq_c = (2*QQ_W)'(uq_s3) * (2*QQ_W)'(uq_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s4 <= flg_s3;
			uq_s4  <= uq_s3;
			u2_s4  <= sq_c[60:30];
			x_s4   <= x_s3;
		end
	end

	// stages 5 to 9: Horner steps, one multiply each
	logic [4:0]       hv_q;
	swc_flag_t        hf_q [5];
	logic [QQ_W-1:0]  hp_q [5];
	logic [QQ_W-1:0]  hu2_q [5];
	logic [QQ_W-1:0]  huq_q [5];
	logic [DIV_W-1:0] hx_q [5];

	for (genvar k = 0; k < 5; k++) begin : g_horner
		logic              p_vld;
		swc_flag_t         p_flg;
		logic [QQ_W-1:0]   p_acc, p_u2, p_uq;
		logic [DIV_W-1:0]  p_x;
		logic [2*QQ_W-1:0] prod;

		if (k == 0) begin : g_first
			assign p_vld = vld_s4;
			assign p_flg = flg_s4;
			assign p_acc = SIN_C11;
			assign p_u2  = u2_s4;
			assign p_uq  = uq_s4;
			assign p_x   = x_s4;
		end else begin : g_next
			assign p_vld = hv_q[k-1];
			assign p_flg = hf_q[k-1];
			assign p_acc = hp_q[k-1];
			assign p_u2  = hu2_q[k-1];
			assign p_uq  = huq_q[k-1];
			assign p_x   = hx_q[k-1];
		end

		assign prod = (2*QQ_W)'(p_u2) * (2*QQ_W)'(p_acc);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_q[k] <= 1'b0;
			end else if (en) begin
				hv_q[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hf_q[k]  <= p_flg;
				hp_q[k]  <= HORNER_C[k] - prod[60:30];
				hu2_q[k] <= p_u2;
				huq_q[k] <= p_uq;
				hx_q[k]  <= p_x;
			end
		end
	end

	// stage 10: sine magnitude
	logic [2*QQ_W-1:0] sin_c;
	logic              vld_s10;
	swc_flag_t         flg_s10;
	logic [QQ_W-1:0]   sin_s10;
	logic [DIV_W-1:0]  x_s10;

	assign sin_c = (2*QQ_W)'(huq_q[4]) * (2*QQ_W)'(hp_q[4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= hv_q[4];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s10 <= hf_q[4];
			sin_s10 <= sin_c[60:30];
			x_s10   <= hx_q[4];
		end
	end

	// stage 11: rounded numerator and overflow check
	logic [DIV_W-1:0] numf_c;
	logic             vld_s11;
	swc_flag_t        flg_s11;
	logic             ovf_s11;
	logic [DIV_W-1:0] numf_s11;
	logic [DIV_W-1:0] x_s11;

	assign numf_c = {6'b0, sin_s10, 10'b0} + {1'b0, x_s10[DIV_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s11  <= flg_s10;
			ovf_s11  <= {{QF_W{1'b0}}, numf_c[DIV_W-1:QF_W]} >= x_s10;
			numf_s11 <= numf_c;
			x_s11    <= x_s10;
		end
	end

	// divide by the angle; the quotient fits 18 bits unless flagged
	logic [0:0][QF_W-1:0]  fin_num;
	logic [0:0][DIV_W-1:0] fin_rem;
	logic                  fin_vld;
	logic [0:0][QF_W-1:0]  fin_quo;
	logic [3:0]            fin_side;
	swc_flag_t             fin_flg;
	logic                  fin_ovf;

	assign fin_num[0] = numf_s11[QF_W-1:0];
	assign fin_rem[0] = ovf_s11 ? '0 : {{QF_W{1'b0}}, numf_s11[DIV_W-1:QF_W]};

	swc_div_pipe #(.N(QF_W), .M(DIV_W), .L(1), .SW(4)) u_fin_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s11),
		.in_num   (fin_num),
		.in_rem   (fin_rem),
		.in_den   (x_s11),
		.in_side  ({flg_s11, ovf_s11}),
		.out_vld  (fin_vld),
		.out_quo  (fin_quo),
		.out_side (fin_side)
	);

	assign fin_flg = fin_side[3:1];
	assign fin_ovf = fin_side[0];

	// output register: saturate, sign, special cases
	logic [VAL_W-1:0] mag_c, val_c;
	logic             out_vld_q;
	logic [VAL_W-1:0] out_val_q;
	logic             out_oor_q;

	always_comb begin
		mag_c = (fin_ovf || fin_quo[0] > VAL_ONE) ? VAL_ONE : fin_quo[0];
		if (fin_flg.oor) begin
			val_c = '0;
		end else if (fin_flg.dz) begin
			val_c = VAL_ONE;
		end else if (fin_flg.neg) begin
			val_c = ~mag_c + VAL_W'(1);
		end else begin
			val_c = mag_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= fin_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_val_q <= val_c;
			out_oor_q <= fin_flg.oor;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b0, out_val_q};
	assign m_tuser  = out_oor_q;

	`include "assert_macros.svh"

	`SWC_ASSERT_IMP(a_oor_zero, m_tvalid && m_tuser, m_tdata[17:0] == 18'd0)
	`SWC_ASSERT_IMP(a_val_range, m_tvalid && !m_tuser, ($signed(m_tdata[17:0]) <= 18'sd65536) && ($signed(m_tdata[17:0]) >= -18'sd65536))
	`SWC_ASSERT_NXT(a_stall_hold, !en && vld_s1, vld_s1 && $stable(d_s1))

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import swc_pkg::*;

	localparam int LATENCY = 77;
	localparam int WD_LIMIT = 20000;
	localparam logic [34:0] TWO_PI_Q = 35'd26986075409;

	typedef struct {
		logic [17:0] value;
		logic        oor;
	} coeff_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	swc_reg_t    cfg_index;
	logic [19:0] cfg_data;

	// model copy of the registers
	logic [12:0] win_len;
	logic [19:0] period;

	logic [11:0] index_q[$];
	coeff_t      coeff_q[$];
	int          errors;
	int          idle_cycles;
	int          burst_left;
	int          gap_left;
	bit          in_taken = 1'b0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	sinc_window_coefficient u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// sin over one turn, 24-bit fraction in, Q30 magnitude out
	function automatic logic [63:0] sine_q30(input logic [23:0] frac);
		logic [1:0]  quad;
		logic [63:0] u, uq, u2, acc;
		quad = frac[23:22];
		u = quad[0] ? (64'h400000 - frac[21:0]) : {42'd0, frac[21:0]};
		uq = u << 8;
		u2 = (uq * uq) >> 30;
		acc = 64'd3864;
		acc = 64'd172272 - ((u2 * acc) >> 30);
		acc = 64'd5026995 - ((u2 * acc) >> 30);
		acc = 64'd85569306 - ((u2 * acc) >> 30);
		acc = 64'd693598668 - ((u2 * acc) >> 30);
		acc = 64'd1686629713 - ((u2 * acc) >> 30);
		return (uq * acc) >> 30;
	endfunction

	function automatic coeff_t sinc_coeff(input logic [11:0] idx);
		coeff_t      r;
		logic [63:0] len, c, d, p, t, x, mag;
		len = win_len;
		if (len > 4096)
			len = 4096;
		r.value = '0;
		r.oor = 1'b0;
		if (idx >= len) begin
			r.oor = 1'b1;
			return r;
		end
		c = len >> 1;
		d = (idx >= c) ? (idx - c) : (c - idx);
		if (d == 0) begin
			r.value = 18'd65536;
			return r;
		end
		p = (period == 0) ? 64'd1 : period;
		t = (d << 32) / p;
		x = (d * TWO_PI_Q) / p;
		mag = sine_q30(t[23:0]);
		mag = (mag * 1024 + (x >> 1)) / x;
		if (mag > 65536)
			mag = 65536;
		if (t[23] && mag != 0)
			r.value = 18'(-mag);
		else
			r.value = mag[17:0];
		return r;
	endfunction

	// sender: bursts with random gaps, valid held until the item is taken
	always @(negedge clk) begin
		if (burst_left == 0 && gap_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		if (index_q.size() > 0 && (burst_left > 0 || (s_tvalid && !in_taken))) begin
			s_tvalid <= 1'b1;
			s_tdata <= {4'd0, index_q[0]};
			if (burst_left > 0)
				burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (index_q.size() == 0)
				burst_left = 0;
		end
	end

	// receiver stall pattern, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (($time / 1000) % 3 == 0)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	// predict on input, compare on output
	always @(posedge clk) begin
		in_taken = s_tvalid && s_tready;
		if (arst_n && in_taken) begin
			coeff_q = {coeff_q, sinc_coeff(s_tdata[11:0])};
			void'(index_q.pop_front());
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (coeff_q.size() == 0) begin
				errors++;
				$display("%0t unexpected item: value %0d oor %0b", $time,
					$signed(m_tdata[17:0]), m_tuser);
			end else begin
				if (m_tdata[17:0] !== coeff_q[0].value || m_tuser !== coeff_q[0].oor) begin
					errors++;
					$display("%0t mismatch: expected value %0d oor %0b, got value %0d oor %0b",
						$time, $signed(coeff_q[0].value), coeff_q[0].oor,
						$signed(m_tdata[17:0]), m_tuser);
				end
				void'(coeff_q.pop_front());
			end
		end
	end

	// watchdog on stalled progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_left > 0)
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("** sinc_window_coefficient: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input swc_reg_t which, input logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (which == REG_LENGTH)
			win_len = val[12:0];
		else
			period = val;
	endtask

	task automatic drain();
		while (index_q.size() > 0 || coeff_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic add_index(input logic [11:0] idx);
		index_q = {index_q, idx};
	endtask

	task automatic random_indices(input int count);
		logic [12:0] eff;
		eff = (win_len > 4096) ? 13'd4096 : win_len;
		for (int i = 0; i < count; i++) begin
			if (eff != 0 && $urandom_range(0, 7) != 0)
				add_index(12'($urandom_range(0, eff - 1)));
			else
				add_index(12'($urandom));
		end
	endtask

	initial begin
		logic [12:0] lens[6];
		logic [19:0] pers[6];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LENGTH;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		win_len = 13'd1;
		period = 20'd1024;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: length one, only the center index is in range
		add_index(12'd0);
		add_index(12'd1);
		add_index(12'd4095);
		drain();

		// directed: full window, extremes, center, period 0/max, other lengths
		write_reg(REG_LENGTH, 20'd4096);
		write_reg(REG_PERIOD, 20'd1024);
		add_index(12'd0);
		add_index(12'd4095);
		add_index(12'd2048);
		add_index(12'd2047);
		add_index(12'd2049);
		add_index(12'd2050);
		add_index(12'd2052);
		add_index(12'hAAA);
		add_index(12'h555);
		drain();
		write_reg(REG_PERIOD, 20'd0);
		add_index(12'd2049);
		add_index(12'd0);
		drain();
		write_reg(REG_PERIOD, 20'hFFFFF);
		add_index(12'd2049);
		add_index(12'd0);
		drain();
		write_reg(REG_LENGTH, 20'h1FFF);
		add_index(12'd4095);
		add_index(12'd1);
		drain();
		write_reg(REG_LENGTH, 20'd0);
		add_index(12'd0);
		add_index(12'd4095);
		drain();
		write_reg(REG_LENGTH, 20'd7);
		write_reg(REG_PERIOD, 20'd256);
		for (int i = 0; i < 8; i++)
			add_index(12'(i));
		drain();

		// long receiver hold-off while the sender keeps offering items
		random_indices(150);
		hold_reqs++;
		repeat (2) @(negedge clk);
		wait (hold_left == 0);
		drain();

		// random phases over several settings
		lens = '{13'd4096, 13'd1, 13'd33, 13'd1000, 13'd5000, 13'd2};
		pers = '{20'd1, 20'd300, 20'd4096, 20'd77777, 20'hFFFFF, 20'd0};
		for (int ph = 0; ph < 12; ph++) begin
			if (ph < 6) begin
				write_reg(REG_LENGTH, {7'd0, lens[ph]});
				write_reg(REG_PERIOD, pers[ph]);
			end else begin
				write_reg(REG_LENGTH, 20'($urandom_range(0, 8191)));
				write_reg(REG_PERIOD, 20'($urandom_range(0, 20'hFFFFF)));
			end
			random_indices(100);
			drain();
		end

		if (errors == 0)
			$display("** sinc_window_coefficient: PASSED **");
		else
			$display("** sinc_window_coefficient: FAILED **");
		$finish;
	end

endmodule
